// File: src/irpdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package irpdt_pkg;

	localparam int MAX_BITS = 64;
	localparam int BITS_W   = $clog2(MAX_BITS + 1);
	localparam int IDX_W    = $clog2(MAX_BITS);

	localparam int CODE_W   = 64;
	localparam int COUNT_W  = 7;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 8;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam int HALF_W   = 8;
	localparam int CYC_W    = 10;
	localparam int MICRO_W  = 16;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_LEAD_MARK  = 3'd1,
		PH_LEAD_SPACE = 3'd2,
		PH_BIT_MARK   = 3'd3,
		PH_BIT_SPACE  = 3'd4,
		PH_TRAILER    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		REG_CARRIER_HIGH = 3'd0,
		REG_CARRIER_LOW  = 3'd1,
		REG_LEAD_MARK    = 3'd2,
		REG_LEAD_SPACE   = 3'd3,
		REG_ONE_MARK     = 3'd4,
		REG_ZERO_MARK    = 3'd5,
		REG_ONE_SPACE    = 3'd6,
		REG_ZERO_SPACE   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic frame_done;
		logic load_rejected;
	} result_t;

endpackage
`default_nettype wire

// File: src/ir_pulse_distance_transmitter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Infrared pulse-distance transmitter. Each input transfer is either a load (tuser high: code
// bits, bit count, trailer flag) or a one-microsecond tick (tuser low); each gives exactly one
// result transfer carrying the output level, busy and rejected flags, with tlast marking the tick
// that ends a frame or the load of a frame with no segments. One item is taken per clock while
// the skid register is empty: all segment sequencing, including skipping any run of empty
// segments, is settled combinationally between the state registers and the result buffer. A
// two-entry result buffer (output register plus skid register) keeps the input side ready
// while one result waits. Timing registers are written over the APB port at byte address 4*i
// and take effect when the next segment or carrier half that uses them starts.
module ir_pulse_distance_transmitter_unit
	import irpdt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              s_tvalid,
	output      logic              s_tready,
	// code_bits [63:0], bit_count [70:64], send_trailer [71]
	input  wire logic [IN_W-1:0]   s_tdata,
	// mode [0]
	input  wire logic              s_tuser,

	output      logic              m_tvalid,
	input  wire logic              m_tready,
	// ir_level [0], busy_res [1], load_rejected [2], zero fill [7:3]
	output      logic [OUT_W-1:0]  m_tdata,
	output      logic              m_tlast,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output      logic [DATA_W-1:0] prdata,
	output      logic              pready
);

	// configuration registers
	logic [HALF_W-1:0]  car_high_q, car_low_q;
	logic [CYC_W-1:0]   lead_mark_q, one_mark_q, zero_mark_q;
	logic [MICRO_W-1:0] lead_space_q, one_space_q, zero_space_q;

	// transmitter state
	phase_t              phase_q;
	logic [CODE_W-1:0]   shift_q;
	logic [BITS_W-1:0]   bits_q;
	logic                trailer_q;
	logic [CYC_W-1:0]    cycles_q;
	logic [MICRO_W-1:0]  micro_q;
	logic                high_q;

	// result buffer
	logic                out_valid_q, skid_valid_q;
	result_t             out_q, skid_q;

	logic                accept, pop, cfg_wr;
	logic                is_load, busy, is_mark;
	reg_idx_t            cfg_idx;

	logic [CODE_W-1:0]   in_code;
	logic [COUNT_W-1:0]  in_count;
	logic [BITS_W-1:0]   in_bits;
	logic                in_trailer;

	logic                car_ne, car_high_first;
	logic [MICRO_W-1:0]  car_micro;
	logic                lead_ne, ls_ne, one_mne, zero_mne, keep1, keep0;

	// tick results
	logic                half_end, ended;
	logic [MICRO_W-1:0]  micro_dec;
	logic [CYC_W-1:0]    cyc_dec;
	logic [CYC_W-1:0]    t_cycles;
	logic [MICRO_W-1:0]  t_micro;
	logic                t_high;

	// segment search results
	phase_t              sk_phase;
	logic [BITS_W-1:0]   sk_bits;
	logic                sk_trailer;
	logic [CYC_W-1:0]    sk_cycles;
	logic [MICRO_W-1:0]  sk_micro;
	logic                sk_high;

	result_t             res;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign pop      = out_valid_q && m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.load_rejected, out_q.busy_res, out_q.ir_level};
	assign m_tlast  = out_q.frame_done;

	assign is_load    = s_tuser;
	assign in_code    = s_tdata[CODE_W-1:0];
	assign in_count   = s_tdata[CODE_W+COUNT_W-1:CODE_W];
	assign in_trailer = s_tdata[CODE_W+COUNT_W];
	assign in_bits    = (in_count > COUNT_W'(MAX_BITS)) ? BITS_W'(MAX_BITS) : BITS_W'(in_count);

	assign busy    = phase_q != PH_IDLE;
	assign is_mark = (phase_q == PH_LEAD_MARK) || (phase_q == PH_BIT_MARK) ||
	                 (phase_q == PH_TRAILER);

	assign car_ne         = (car_high_q != '0) || (car_low_q != '0);
	assign car_high_first = car_high_q != '0;
	assign car_micro      = car_high_first ? MICRO_W'(car_high_q) : MICRO_W'(car_low_q);
	assign lead_ne        = (lead_mark_q != '0) && car_ne;
	assign ls_ne          = lead_space_q != '0;
	assign one_mne        = (one_mark_q != '0) && car_ne;
	assign zero_mne       = (zero_mark_q != '0) && car_ne;
	assign keep1          = one_mne || (one_space_q != '0);
	assign keep0          = zero_mne || (zero_space_q != '0);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_high_q   <= HALF_W'(13);
			car_low_q    <= HALF_W'(13);
			lead_mark_q  <= CYC_W'(340);
			lead_space_q <= MICRO_W'(4496);
			one_mark_q   <= CYC_W'(20);
			zero_mark_q  <= CYC_W'(20);
			one_space_q  <= MICRO_W'(1711);
			zero_space_q <= MICRO_W'(594);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_CARRIER_HIGH: car_high_q   <= pwdata[HALF_W-1:0];
				REG_CARRIER_LOW:  car_low_q    <= pwdata[HALF_W-1:0];
				REG_LEAD_MARK:    lead_mark_q  <= pwdata[CYC_W-1:0];
				REG_LEAD_SPACE:   lead_space_q <= pwdata[MICRO_W-1:0];
				REG_ONE_MARK:     one_mark_q   <= pwdata[CYC_W-1:0];
				REG_ZERO_MARK:    zero_mark_q  <= pwdata[CYC_W-1:0];
				REG_ONE_SPACE:    one_space_q  <= pwdata[MICRO_W-1:0];
				REG_ZERO_SPACE:   zero_space_q <= pwdata[MICRO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_CARRIER_HIGH: prdata = DATA_W'(car_high_q);
			REG_CARRIER_LOW:  prdata = DATA_W'(car_low_q);
			REG_LEAD_MARK:    prdata = DATA_W'(lead_mark_q);
			REG_LEAD_SPACE:   prdata = DATA_W'(lead_space_q);
			REG_ONE_MARK:     prdata = DATA_W'(one_mark_q);
			REG_ZERO_MARK:    prdata = DATA_W'(zero_mark_q);
			REG_ONE_SPACE:    prdata = DATA_W'(one_space_q);
			REG_ZERO_SPACE:   prdata = DATA_W'(zero_space_q);
			default:          prdata = '0;
		endcase
	end

	// one microsecond of the current segment
	assign half_end  = micro_q <= MICRO_W'(1);
	assign micro_dec = (micro_q == '0) ? '0 : micro_q - MICRO_W'(1);
	assign cyc_dec   = (cycles_q == '0) ? '0 : cycles_q - CYC_W'(1);

	always_comb begin
		t_cycles = cycles_q;
		t_micro  = micro_dec;
		t_high   = high_q;
		ended    = 1'b0;
		if (is_mark) begin
			if (half_end) begin
				if (high_q && (car_low_q != '0)) begin
					t_high  = 1'b0;
					t_micro = MICRO_W'(car_low_q);
				end else begin
					t_cycles = cyc_dec;
					if ((cyc_dec != '0) && car_ne) begin
						t_high  = car_high_first;
						t_micro = car_micro;
					end else begin
						ended = 1'b1;
					end
				end
			end
		end else if (half_end) begin
			ended = 1'b1;
		end
	end

	// next non-empty segment after the one that ended (or after a load)
	always_comb begin
		phase_t             ent;
		logic               e_idle, e_lm, e_ls, e_bm, e_bs;
		logic [CODE_W-1:0]  shf;
		logic [BITS_W-1:0]  bl, bl_dec, lim;
		logic               trl, cur_bit, cur_sp_ne, after_lm, search_on, found, bj;
		logic [MICRO_W-1:0] cur_sp;
		logic [IDX_W-1:0]   j;
		logic [MAX_BITS-1:0] cand;

		ent       = is_load ? PH_IDLE : phase_q;
		shf       = is_load ? in_code : shift_q;
		bl        = is_load ? in_bits : bits_q;
		trl       = is_load ? in_trailer : trailer_q;
		e_idle    = ent == PH_IDLE;
		e_lm      = ent == PH_LEAD_MARK;
		e_ls      = ent == PH_LEAD_SPACE;
		e_bm      = ent == PH_BIT_MARK;
		e_bs      = ent == PH_BIT_SPACE;
		bl_dec    = (bl == '0) ? '0 : bl - BITS_W'(1);
		cur_bit   = (bl != '0) && shf[IDX_W'(bl_dec)];
		cur_sp    = cur_bit ? one_space_q : zero_space_q;
		cur_sp_ne = cur_sp != '0;
		after_lm  = e_lm || (e_idle && !lead_ne);
		search_on = (after_lm && !ls_ne) || e_ls || e_bs || (e_bm && !cur_sp_ne);
		lim       = (e_bs || e_bm) ? bl_dec : bl;

		for (int i = 0; i < MAX_BITS; i++) begin
			cand[i] = (BITS_W'(i) < lim) && (shf[i] ? keep1 : keep0);
		end
		found = 1'b0;
		j     = '0;
		for (int i = 0; i < MAX_BITS; i++) begin
			if (cand[i]) begin
				found = 1'b1;
				j     = IDX_W'(i);
			end
		end
		bj = shf[j];

		sk_phase   = PH_IDLE;
		sk_bits    = bl;
		sk_trailer = trl;
		sk_cycles  = cycles_q;
		sk_micro   = micro_q;
		sk_high    = high_q;

		if (e_idle && lead_ne) begin
			sk_phase  = PH_LEAD_MARK;
			sk_cycles = lead_mark_q;
			sk_high   = car_high_first;
			sk_micro  = car_micro;
		end else if (after_lm && ls_ne) begin
			sk_phase = PH_LEAD_SPACE;
			sk_micro = lead_space_q;
		end else if (e_bm && cur_sp_ne) begin
			sk_phase = PH_BIT_SPACE;
			sk_micro = cur_sp;
		end else if (search_on) begin
			if (found) begin
				sk_bits = BITS_W'(j) + BITS_W'(1);
				if (bj ? one_mne : zero_mne) begin
					sk_phase  = PH_BIT_MARK;
					sk_cycles = bj ? one_mark_q : zero_mark_q;
					sk_high   = car_high_first;
					sk_micro  = car_micro;
				end else begin
					sk_phase = PH_BIT_SPACE;
					sk_micro = bj ? one_space_q : zero_space_q;
				end
			end else begin
				sk_bits    = '0;
				sk_trailer = 1'b0;
				if (trl && one_mne) begin
					sk_phase  = PH_TRAILER;
					sk_cycles = one_mark_q;
					sk_high   = car_high_first;
					sk_micro  = car_micro;
				end
			end
		end
	end

	// result of the item
	always_comb begin
		res = '0;
		if (is_load) begin
			if (busy) begin
				res.load_rejected = 1'b1;
				res.busy_res      = 1'b1;
			end else begin
				res.busy_res   = sk_phase != PH_IDLE;
				res.frame_done = sk_phase == PH_IDLE;
			end
		end else if (busy) begin
			res.busy_res   = 1'b1;
			res.ir_level   = is_mark && high_q;
			res.frame_done = ended && (sk_phase == PH_IDLE);
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			shift_q   <= '0;
			bits_q    <= '0;
			trailer_q <= 1'b0;
			cycles_q  <= '0;
			micro_q   <= '0;
			high_q    <= 1'b0;
		end else if (accept) begin
			if (is_load) begin
				if (!busy) begin
					phase_q   <= sk_phase;
					shift_q   <= in_code;
					bits_q    <= sk_bits;
					trailer_q <= sk_trailer;
					cycles_q  <= sk_cycles;
					micro_q   <= sk_micro;
					high_q    <= sk_high;
				end
			end else if (busy) begin
				if (ended) begin
					phase_q   <= sk_phase;
					bits_q    <= sk_bits;
					trailer_q <= sk_trailer;
					cycles_q  <= sk_cycles;
					micro_q   <= sk_micro;
					high_q    <= sk_high;
				end else begin
					cycles_q <= t_cycles;
					micro_q  <= t_micro;
					high_q   <= t_high;
				end
			end
		end
	end

	// result buffer with skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_valid_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without output entry");

	a_active_has_time: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (micro_q != '0))
		else $error("active segment with no time left");

	a_mark_has_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_LEAD_MARK) || (phase_q == PH_BIT_MARK) || (phase_q == PH_TRAILER))
		|-> (cycles_q != '0))
		else $error("mark running with no carrier cycles left");

	a_bits_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BITS_W'(MAX_BITS))
		else $error("bit count beyond frame size");
`endif

endmodule
`default_nettype wire

// File: bench/tb_ir_pulse_distance_transmitter_unit.sv
`timescale 1ns / 1ps
module tb_ir_pulse_distance_transmitter_unit;
	import irpdt_pkg::*;

	localparam int LIMIT = 2_000_000;

	typedef struct packed {
		logic        load;
		logic [63:0] code;
		logic [6:0]  cnt;
		logic        trl;
	} ir_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	ir_pulse_distance_transmitter_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timing registers as the block holds them
	logic [7:0]  t_high = 8'd13;
	logic [7:0]  t_low = 8'd13;
	logic [9:0]  t_lead_mark = 10'd340;
	logic [15:0] t_lead_space = 16'd4496;
	logic [9:0]  t_one_mark = 10'd20;
	logic [9:0]  t_zero_mark = 10'd20;
	logic [15:0] t_one_space = 16'd1711;
	logic [15:0] t_zero_space = 16'd594;

	// frame sequencer state
	phase_t      ir_phase = PH_IDLE;
	logic [63:0] code_shift = '0;
	int unsigned bits_pending = 0;
	logic        trailer_due = 1'b0;
	logic [9:0]  cycles_due = '0;
	logic [15:0] ticks_due = '0;
	logic        in_high = 1'b0;

	ir_cmd_t cmd_q[$];
	result_t expected_results[$];
	ir_cmd_t on_bus;
	result_t want_r;
	int      queued_items = 0;
	int      mismatches = 0;
	int      cycle_count = 0;
	int      send_gap = 0;
	int      send_burst = 0;
	int      hold_left = 0;
	int      ready_burst = 0;
	int      roll;
	bit      long_hold_done = 1'b0;

	function automatic void set_timing(reg_idx_t idx, logic [15:0] value);
		case (idx)
		REG_CARRIER_HIGH: t_high = value[7:0];
		REG_CARRIER_LOW: t_low = value[7:0];
		REG_LEAD_MARK: t_lead_mark = value[9:0];
		REG_LEAD_SPACE: t_lead_space = value;
		REG_ONE_MARK: t_one_mark = value[9:0];
		REG_ZERO_MARK: t_zero_mark = value[9:0];
		REG_ONE_SPACE: t_one_space = value;
		default: t_zero_space = value;
		endcase
	endfunction

	function automatic logic code_bit();
		if (bits_pending == 0)
			return 1'b0;
		return code_shift[bits_pending - 1];
	endfunction

	function automatic logic open_cycle();
		if (cycles_due == 0)
			return 1'b0;
		if (t_high != 0) begin
			in_high = 1'b1;
			ticks_due = 16'(t_high);
			return 1'b1;
		end
		if (t_low != 0) begin
			in_high = 1'b0;
			ticks_due = 16'(t_low);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic open_mark(logic [9:0] n);
		cycles_due = n;
		return open_cycle();
	endfunction

	// moves past every empty segment after the one that ended
	function automatic logic advance_segment(phase_t ended);
		phase_t      p;
		logic [15:0] gap;
		logic        found;
		logic        stop;
		p = ended;
		found = 1'b0;
		stop = 1'b0;
		while (!stop) begin
			case (p)
			PH_IDLE: begin
				if (open_mark(t_lead_mark)) begin
					ir_phase = PH_LEAD_MARK;
					found = 1'b1;
					stop = 1'b1;
				end else
					p = PH_LEAD_MARK;
			end
			PH_LEAD_MARK: begin
				if (t_lead_space != 0) begin
					ticks_due = t_lead_space;
					ir_phase = PH_LEAD_SPACE;
					found = 1'b1;
					stop = 1'b1;
				end else
					p = PH_LEAD_SPACE;
			end
			PH_LEAD_SPACE: begin
				if (bits_pending != 0) begin
					if (open_mark(code_bit() ? t_one_mark : t_zero_mark)) begin
						ir_phase = PH_BIT_MARK;
						found = 1'b1;
						stop = 1'b1;
					end else
						p = PH_BIT_MARK;
				end else begin
					p = PH_TRAILER;
					if (trailer_due) begin
						trailer_due = 1'b0;
						if (open_mark(t_one_mark)) begin
							ir_phase = PH_TRAILER;
							found = 1'b1;
							stop = 1'b1;
						end
					end
				end
			end
			PH_BIT_MARK: begin
				gap = code_bit() ? t_one_space : t_zero_space;
				if (gap != 0) begin
					ticks_due = gap;
					ir_phase = PH_BIT_SPACE;
					found = 1'b1;
					stop = 1'b1;
				end else
					p = PH_BIT_SPACE;
			end
			PH_BIT_SPACE: begin
				if (bits_pending != 0)
					bits_pending--;
				p = PH_LEAD_SPACE;
			end
			default: begin
				ir_phase = PH_IDLE;
				stop = 1'b1;
			end
			endcase
		end
		return found;
	endfunction

	function automatic result_t predict_ir_result(ir_cmd_t c);
		result_t r;
		logic    mark;
		logic    ended;
		r = '0;
		ended = 1'b0;
		if (c.load) begin
			if (ir_phase != PH_IDLE) begin
				r.load_rejected = 1'b1;
				r.busy_res = 1'b1;
			end else begin
				bits_pending = (c.cnt > MAX_BITS) ? MAX_BITS : c.cnt;
				code_shift = c.code;
				trailer_due = c.trl;
				if (advance_segment(PH_IDLE))
					r.busy_res = 1'b1;
				else
					r.frame_done = 1'b1;
			end
		end else if (ir_phase != PH_IDLE) begin
			mark = ir_phase == PH_LEAD_MARK || ir_phase == PH_BIT_MARK ||
				ir_phase == PH_TRAILER;
			r.busy_res = 1'b1;
			r.ir_level = mark && in_high;
			if (ticks_due != 0)
				ticks_due--;
			if (ticks_due == 0) begin
				if (!mark)
					ended = 1'b1;
				else if (in_high && t_low != 0) begin
					in_high = 1'b0;
					ticks_due = 16'(t_low);
				end else begin
					if (cycles_due != 0)
						cycles_due--;
					ended = !open_cycle();
				end
			end
			if (ended && !advance_segment(ir_phase))
				r.frame_done = 1'b1;
		end
		return r;
	endfunction

	// ticks a frame lasts when the timing stays as it is
	function automatic int frame_ticks(ir_cmd_t c);
		int per;
		int total;
		int n;
		per = int'(t_high) + int'(t_low);
		n = (c.cnt > MAX_BITS) ? MAX_BITS : int'(c.cnt);
		total = per * int'(t_lead_mark) + int'(t_lead_space);
		for (int i = n - 1; i >= 0; i--)
			total += c.code[i] ? per * int'(t_one_mark) + int'(t_one_space) :
				per * int'(t_zero_mark) + int'(t_zero_space);
		if (c.trl)
			total += per * int'(t_one_mark);
		return total;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (send_burst > 0) begin
			send_burst--;
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(8, 40);
		send_burst = $urandom_range(40, 160);
		return 0;
	endfunction

	function automatic ir_cmd_t random_tick();
		ir_cmd_t c;
		c.load = 1'b0;
		c.code = {$urandom, $urandom};
		c.cnt = 7'($urandom);
		c.trl = 1'($urandom);
		return c;
	endfunction

	function automatic ir_cmd_t make_load(logic [63:0] code, logic [6:0] cnt, logic trl);
		ir_cmd_t c;
		c.load = 1'b1;
		c.code = code;
		c.cnt = cnt;
		c.trl = trl;
		return c;
	endfunction

	task automatic push_cmd(ir_cmd_t c);
		cmd_q.push_back(c);
		queued_items++;
	endtask

	task automatic push_ticks(int n);
		repeat (n) push_cmd(random_tick());
	endtask

	// load, ticks for the frame less trim, then tail ticks; optionally a stray load inside it
	task automatic run_frame(ir_cmd_t f, bit stray, int trim, int tail);
		int n;
		int at;
		n = frame_ticks(f) - trim;
		if (n < 0)
			n = 0;
		at = (stray && n > 0) ? $urandom_range(0, n - 1) : -1;
		push_cmd(f);
		for (int i = 0; i < n; i++) begin
			if (i == at)
				push_cmd(make_load({$urandom, $urandom}, 7'($urandom), 1'($urandom)));
			push_cmd(random_tick());
		end
		push_ticks(tail);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_q.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	task automatic write_timing(reg_idx_t idx, logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		set_timing(idx, value);
	endtask

	task automatic write_all_timing(int h, int l, int lm, int ls, int om, int zm, int os,
			int zs);
		write_timing(REG_CARRIER_HIGH, 16'(h));
		write_timing(REG_CARRIER_LOW, 16'(l));
		write_timing(REG_LEAD_MARK, 16'(lm));
		write_timing(REG_LEAD_SPACE, 16'(ls));
		write_timing(REG_ONE_MARK, 16'(om));
		write_timing(REG_ZERO_MARK, 16'(zm));
		write_timing(REG_ONE_SPACE, 16'(os));
		write_timing(REG_ZERO_SPACE, 16'(zs));
	endtask

	task automatic check_field(string what, logic want, logic got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %b actual %b", $time, what, want, got);
		end
	endtask

	// input side: transfers from the pending queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_ir_result(on_bus));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					on_bus = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= on_bus.load;
					s_tdata <= {on_bus.trl, on_bus.cnt, on_bus.code};
					send_gap = pick_gap();
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// output side stalls, one long hold-off while the input queue is deep
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!long_hold_done && cmd_q.size() > 200) begin
			long_hold_done = 1'b1;
			hold_left = 400;
			m_tready <= 1'b0;
		end else if (ready_burst > 0) begin
			ready_burst--;
			m_tready <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				m_tready <= 1'b1;
			end else if (roll < 90) begin
				hold_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else if (roll < 97) begin
				hold_left = $urandom_range(8, 40);
				m_tready <= 1'b0;
			end else begin
				ready_burst = $urandom_range(40, 160);
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result transfer with none expected, expected none actual %h/%b",
					$time, m_tdata, m_tlast);
			end else begin
				want_r = expected_results.pop_front();
				check_field("ir_level", want_r.ir_level, m_tdata[0]);
				check_field("busy_res", want_r.busy_res, m_tdata[1]);
				check_field("load_rejected", want_r.load_rejected, m_tdata[2]);
				check_field("frame_done", want_r.frame_done, m_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("tb_ir_pulse_distance_transmitter_unit NOT OK");
			$finish;
		end
	end

	initial begin
		int      r;
		ir_cmd_t f;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_all_timing(1, 1, 1, 1, 2, 1, 2, 1);
		push_ticks(1);
		run_frame(make_load(64'h2, 7'd2, 1'b1), 1'b1, 0, 2);
		wait_drained();

		// every segment empty, oversized bit count
		write_all_timing(1, 1, 0, 0, 0, 0, 0, 0);
		push_cmd(make_load(64'h0, 7'd0, 1'b0));
		push_cmd(make_load(64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1));
		push_ticks(1);
		wait_drained();

		// high half skipped, full code width
		write_all_timing(0, 1, 0, 0, 1, 0, 1, 0);
		run_frame(make_load(64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b1), 1'b0, 0, 1);
		run_frame(make_load(64'h0, 7'd127, 1'b1), 1'b0, 0, 1);
		wait_drained();

		write_all_timing(255, 0, 1, 0, 1023, 0, 65535, 0);
		run_frame(make_load(64'h0, 7'd64, 1'b0), 1'b0, 0, 1);
		wait_drained();

		// long leading mark cut short by clearing the carrier
		write_all_timing(1, 0, 1023, 0, 0, 0, 0, 0);
		push_cmd(make_load({$urandom, $urandom}, 7'd0, 1'b0));
		push_ticks(5);
		wait_drained();
		write_timing(REG_CARRIER_HIGH, 16'd0);
		push_ticks(3);
		wait_drained();

		// both carrier times cleared in the middle of the leading mark
		write_all_timing(2, 2, 3, 2, 1, 1, 1, 1);
		push_cmd(make_load(64'h1, 7'd1, 1'b0));
		push_ticks(3);
		wait_drained();
		write_timing(REG_CARRIER_HIGH, 16'd0);
		write_timing(REG_CARRIER_LOW, 16'd0);
		push_ticks(30);
		wait_drained();

		while (queued_items < 950) begin
			wait_drained();
			if ($urandom_range(0, 5) == 0)
				write_all_timing(0, 0, $urandom_range(0, 3), $urandom_range(0, 8),
					$urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 8),
					$urandom_range(0, 8));
			else
				write_all_timing($urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 3), $urandom_range(0, 8), $urandom_range(0, 3),
					$urandom_range(0, 3), $urandom_range(0, 8), $urandom_range(0, 8));
			repeat ($urandom_range(3, 6)) begin
				r = $urandom_range(0, 99);
				f = make_load({$urandom, $urandom},
					(r < 70) ? 7'($urandom_range(0, 8)) :
					(r < 92) ? 7'($urandom_range(9, 32)) : 7'($urandom_range(64, 127)),
					1'($urandom));
				run_frame(f, $urandom_range(0, 99) < 15,
					($urandom_range(0, 99) < 6) ? $urandom_range(1, 4) : 0,
					($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_ir_pulse_distance_transmitter_unit OK");
		else
			$display("tb_ir_pulse_distance_transmitter_unit NOT OK");
		$finish;
	end

endmodule
